// ===== sv/vadpcm_pkg.sv =====
// vadpcm_pkg: types and constants for the order-2 vector adpcm frame decoder
// used by adpcm_frame_decoder_order2_core; depends on nothing

package vadpcm_pkg;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_LOAD   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         header_byte;
    logic [63:0]        frame_nibbles;
    logic [6:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] hist_older;
    logic signed [15:0] hist_newer;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_of_frame;
  } out_item_t;

  localparam int unsigned SCALE_MAX = 12;
  localparam int unsigned FRAC_BITS = 11;
  localparam int unsigned ACC_W     = 36;
  localparam int unsigned HALF_LEN  = 8;
  localparam int unsigned ROW_LEN   = 16;

  localparam logic signed [15:0] SMP_MIN = -16'sd32768;
  localparam logic signed [15:0] SMP_MAX = 16'sd32767;

endpackage

// ===== sv/vadpcm_ram.sv =====
// vadpcm_ram: generic single-write, single-read ram with registered read data
// no dependencies

module vadpcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/adpcm_frame_decoder_order2_core.sv =====
// adpcm_frame_decoder_order2_core: order-2 vector adpcm frame decoder top level
// depends on vadpcm_pkg and vadpcm_ram

// A decode transfer carries one frame and yields sixteen sample transfers, the
// last one flagged. Samples are built by one 16x16 multiply-accumulate unit that
// reads the codebook ram one coefficient per cycle: sample i of each half-frame
// takes i+2 products, after which the product pipeline drains and the sample
// waits until the output register is free. Codebook write, history load and
// unused opcodes give no output. Inputs are taken only while no frame is being
// decoded; the final sample may still wait in the output register. Codebook
// entries read as zero until written, tracked by one valid flop per entry
// cleared at reset, so no clearing pass is needed.

module adpcm_frame_decoder_order2_core #(
  parameter int unsigned MAX_PREDICTORS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vadpcm_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vadpcm_pkg::out_item_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [3:0]            cfg_wdata_i
);

  localparam int unsigned DEPTH = MAX_PREDICTORS * vadpcm_pkg::ROW_LEN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned QW    = vadpcm_pkg::ACC_W - vadpcm_pkg::FRAC_BITS;

  vadpcm_pkg::state_e state_q, state_d;

  logic [3:0]          num_pred_q;
  logic [63:0]         frame_q;
  logic [3:0]          scale_q;
  logic [3:0]          pred_q;
  logic                half_q, half_d;
  logic [2:0]          idx_q, idx_d;
  logic [3:0]          term_q, term_d;
  logic signed [15:0]  hist_older_q, hist_newer_q;
  logic signed [15:0]  last_smp_q;
  logic                v1_q, v2_q;
  logic signed [15:0]  op_q, op_d;
  logic [AW-1:0]       raddr_q;
  logic signed [31:0]  prod_q;
  logic signed [vadpcm_pkg::ACC_W-1:0] acc_q;
  logic [DEPTH-1:0]    book_vld_q;
  logic                out_valid_q;
  vadpcm_pkg::out_item_t out_q;

  logic                in_fire;
  logic                issue;
  logic                emit;
  logic                wr_en;
  logic [AW+6:0]       waddr_wide;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [15:0]         rdata;
  logic signed [15:0]  coef;
  logic [3:0]          pos;
  logic [3:0]          kk;
  logic [3:0]          ridx;
  logic [3:0]          nib_a [16];
  logic [3:0]          cur_nib;
  logic signed [15:0]  cur_res;
  logic signed [15:0]  op_res;
  logic signed [vadpcm_pkg::ACC_W-1:0] acc_init;
  logic signed [QW-1:0] q_val;
  logic signed [15:0]  smp;
  logic [4:0]          pred_cnt;
  logic [3:0]          pred_sel;
  logic [3:0]          scale_sel;
  logic [7:0]          raddr_wide;
  logic                frame_end;

  for (genvar n = 0; n < 16; n++) begin : g_nib
    assign nib_a[n] = frame_q[63-4*n -: 4];
  end

  assign in_ready_o = (state_q == vadpcm_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // codebook write port
  assign waddr_wide = {{AW{1'b0}}, in_data_i.coef_index};
  assign waddr      = waddr_wide[AW-1:0];
  assign wr_en      = in_fire && (in_data_i.opcode == vadpcm_pkg::OP_WRITE)
                      && (32'(in_data_i.coef_index) < DEPTH);

  // predictor and scale selection at frame start
  assign pred_cnt  = (5'(num_pred_q) > 5'(MAX_PREDICTORS)) ? 5'(MAX_PREDICTORS)
                                                           : 5'(num_pred_q);
  assign pred_sel  = (5'(in_data_i.header_byte[3:0]) < pred_cnt)
                     ? in_data_i.header_byte[3:0] : 4'd0;
  assign scale_sel = (32'(in_data_i.header_byte[7:4]) > vadpcm_pkg::SCALE_MAX)
                     ? 4'(vadpcm_pkg::SCALE_MAX) : in_data_i.header_byte[7:4];

  // term sequencing: r1[i]*h_older, r2[i]*h_newer, then r2[k]*res[i-1-k]
  assign issue = (state_q == vadpcm_pkg::ST_ISSUE);
  assign kk    = term_q - 4'd2;
  assign ridx  = {half_q, idx_q - 3'd1 - kk[2:0]};

  always_comb begin
    pos   = {1'b1, kk[2:0]};
    op_d  = op_res;
    if (term_q == 4'd0) begin
      pos  = {1'b0, idx_q};
      op_d = hist_older_q;
    end else if (term_q == 4'd1) begin
      pos  = {1'b1, idx_q};
      op_d = hist_newer_q;
    end
  end

  assign op_res     = 16'({{12{nib_a[ridx][3]}}, nib_a[ridx]} << scale_q);
  assign raddr_wide = {pred_q, pos};
  assign raddr      = raddr_wide[AW-1:0];

  assign cur_nib  = nib_a[{half_q, idx_q}];
  assign cur_res  = 16'({{12{cur_nib[3]}}, cur_nib} << scale_q);
  assign acc_init = vadpcm_pkg::ACC_W'(cur_res) <<< vadpcm_pkg::FRAC_BITS;

  vadpcm_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_book (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (in_data_i.coef_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign coef = book_vld_q[raddr_q] ? signed'(rdata) : 16'sd0;

  // floor shift and clamp
  assign q_val = acc_q[vadpcm_pkg::ACC_W-1:vadpcm_pkg::FRAC_BITS];
  always_comb begin
    if ((&q_val[QW-1:15]) || !(|q_val[QW-1:15])) begin
      smp = q_val[15:0];
    end else if (q_val[QW-1]) begin
      smp = vadpcm_pkg::SMP_MIN;
    end else begin
      smp = vadpcm_pkg::SMP_MAX;
    end
  end

  assign emit      = (state_q == vadpcm_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign frame_end = half_q && (idx_q == 3'(vadpcm_pkg::HALF_LEN - 1));

  always_comb begin
    state_d = state_q;
    half_d  = half_q;
    idx_d   = idx_q;
    term_d  = term_q;
    case (state_q)
      vadpcm_pkg::ST_IDLE: begin
        if (in_fire && in_data_i.opcode == vadpcm_pkg::OP_DECODE) begin
          state_d = vadpcm_pkg::ST_ISSUE;
          half_d  = 1'b0;
          idx_d   = 3'd0;
          term_d  = 4'd0;
        end
      end
      vadpcm_pkg::ST_ISSUE: begin
        term_d = term_q + 4'd1;
        if (term_q == {1'b0, idx_q} + 4'd1) begin
          state_d = vadpcm_pkg::ST_DRAIN;
        end
      end
      vadpcm_pkg::ST_DRAIN: begin
        if (!v1_q) begin
          state_d = vadpcm_pkg::ST_EMIT;
        end
      end
      vadpcm_pkg::ST_EMIT: begin
        if (emit) begin
          term_d = 4'd0;
          if (frame_end) begin
            state_d = vadpcm_pkg::ST_IDLE;
          end else begin
            state_d = vadpcm_pkg::ST_ISSUE;
            idx_d   = idx_q + 3'd1;
            if (idx_q == 3'(vadpcm_pkg::HALF_LEN - 1)) begin
              half_d = 1'b1;
            end
          end
        end
      end
      default: state_d = vadpcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vadpcm_pkg::ST_IDLE;
      half_q  <= 1'b0;
      idx_q   <= 3'd0;
      term_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
      idx_q   <= idx_d;
      term_q  <= term_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pred_q   <= 4'd1;
      book_vld_q   <= '0;
      hist_older_q <= 16'sd0;
      hist_newer_q <= 16'sd0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_pred_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        book_vld_q[waddr] <= 1'b1;
      end
      if (in_fire && in_data_i.opcode == vadpcm_pkg::OP_LOAD) begin
        hist_older_q <= in_data_i.hist_older;
        hist_newer_q <= in_data_i.hist_newer;
      end
      // history for the second half and for the next frame
      if (emit && idx_q == 3'(vadpcm_pkg::HALF_LEN - 1)) begin
        hist_older_q <= last_smp_q;
        hist_newer_q <= smp;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.opcode == vadpcm_pkg::OP_DECODE) begin
      frame_q <= in_data_i.frame_nibbles;
      scale_q <= scale_sel;
      pred_q  <= pred_sel;
    end
    if (issue) begin
      op_q    <= op_d;
      raddr_q <= raddr;
    end
    prod_q <= coef * op_q;
    if (issue && term_q == 4'd0) begin
      acc_q <= acc_init;
    end else if (v2_q) begin
      acc_q <= acc_q + vadpcm_pkg::ACC_W'(prod_q);
    end
    if (emit) begin
      last_smp_q          <= smp;
      out_q.sample        <= smp;
      out_q.last_of_frame <= frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vadpcm_pkg::ST_EMIT && out_valid_q && !out_ready_i)
    |=> state_q == vadpcm_pkg::ST_EMIT)
    else $error("pending sample overwritten");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && term_q == 4'd0) |-> (!v1_q && !v2_q))
    else $error("product pipeline busy at sample start");

  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (term_q <= {1'b0, idx_q} + 4'd1))
    else $error("term counter overran sample");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && frame_end)
    |=> (state_q == vadpcm_pkg::ST_IDLE && out_valid_q && out_q.last_of_frame))
    else $error("frame end not flagged");
`endif

endmodule
